// File: hdl/prk_pkg.sv
// ----------------------------------------------------------------------------
// PageRank package
// Shared field widths, store depths, payload types and fixed-point constants.
// ----------------------------------------------------------------------------
package prk_pkg;

   localparam int PAGE_W  = 6;
   localparam int RANK_W  = 32;
   localparam int SCORE_W = 13;
   localparam int PCNT_W  = 7;
   localparam int RCNT_W  = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam int MAX_PAGES = 64;
   localparam int MAX_EDGES = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 1'd1;

   localparam logic [31:0] NINE_TENTHS_Q32 = 32'hE6666666;
   localparam logic [31:0] RANK_MAX        = 32'hFFFFFFFF;
   localparam logic [12:0] SCORE_MAX       = 13'd8191;

   typedef struct packed {
      logic              has_edge;
      logic [PAGE_W-1:0] src_page;
      logic [PAGE_W-1:0] dst_page;
      logic              last_edge;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page_index;
      logic [RANK_W-1:0]  rank;
      logic [SCORE_W-1:0] score;
      logic               last_page;
   } rsp_type;

endpackage

// File: hdl/prk_if.sv
// ----------------------------------------------------------------------------
// PageRank stream interface
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface prk_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/prk_ram.sv
// ----------------------------------------------------------------------------
// PageRank generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module prk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/prk_div.sv
// ----------------------------------------------------------------------------
// PageRank divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prk_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = CNT_W'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

// File: hdl/pagerank_power_iteration.sv
// ----------------------------------------------------------------------------
// PageRank power iteration
// Loading: one edge transfer per cycle. A run clears the out-degree store,
// runs the start-up divisions, counts out-degrees over the stored edges and
// sets up the ranks; each round then clears the next ranks, walks every
// stored edge through the serial divider and copies next to rank. Results
// leave one at a time. Reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
module pagerank_power_iteration (
   input  logic                         clock,
   input  logic                         reset,
   prk_if.sink                          req,
   prk_if.source                        rsp,
   input  logic                         csr_wr_en,
   input  logic [prk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prk_pkg::CSR_W-1:0]     csr_wr_data
);
   import prk_pkg::*;

   localparam int PA_W  = $clog2(MAX_PAGES);
   localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EF_W  = $clog2(MAX_EDGES + 1);
   localparam int DEG_W = EF_W;
   localparam int NW    = PCNT_W;

   localparam logic [3:0] S_LOAD = 4'd0, S_INIT = 4'd1, S_DEG_RD = 4'd2,
      S_DEG_WAIT = 4'd3, S_DEG_UPD = 4'd4, S_ACC_CLR = 4'd5, S_E_RD = 4'd6,
      S_E_WAIT = 4'd7, S_E_MUL = 4'd8, S_E_DIV = 4'd9, S_E_ACC = 4'd10,
      S_COPY = 4'd11, S_REP = 4'd12, S_REP_WAIT = 4'd13, S_REP_OUT = 4'd14,
      S_DIVS = 4'd15;

   // configuration
   logic [PCNT_W-1:0] page_count_ff;
   logic [RCNT_W-1:0] round_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PCNT_W'(64); round_count_ff <= RCNT_W'(50);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PAGE_COUNT:  page_count_ff  <= csr_wr_data[PCNT_W-1:0];
            CSR_ROUND_COUNT: round_count_ff <= csr_wr_data[RCNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [NW+PA_W:0] n_used;
   always_comb begin
      n_used = (NW+PA_W+1)'(page_count_ff);
      if (n_used < (NW+PA_W+1)'(1)) n_used = (NW+PA_W+1)'(1);
      if (n_used > (NW+PA_W+1)'(MAX_PAGES)) n_used = (NW+PA_W+1)'(MAX_PAGES);
   end

   logic [3:0]        state_ff, state_in;
   logic [EF_W-1:0]   fill_ff, fill_in, eidx_ff, eidx_in;
   logic [PA_W:0]     pidx_ff, pidx_in;
   logic [RCNT_W-1:0] round_ff, round_in;
   logic [31:0]       base_ff, base_in, start_ff, start_in;
   logic [1:0]        dsel_ff, dsel_in;
   logic [PA_W-1:0]   es_ff, es_in, ed_ff, ed_in;
   logic [63:0]       prod_ff, prod_in;
   logic [31:0]       share_ff, share_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_v_ff, rsp_v_in;

   // memories
   logic              e_we, dg_we, rk_we, nx_we;
   logic [EA_W-1:0]   e_wa, e_ra;
   logic [2*PA_W-1:0] e_wd, e_rd;
   logic [PA_W-1:0]   dg_wa, dg_ra, rk_wa, rk_ra, nx_wa, nx_ra;
   logic [DEG_W-1:0]  dg_wd, dg_rd;
   logic [31:0]       rk_wd, rk_rd, nx_wd, nx_rd;

   prk_ram #(.WIDTH(2*PA_W), .DEPTH(MAX_EDGES)) u_edge (.clock, .wr_en(e_we),
      .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra), .rd_data(e_rd));
   prk_ram #(.WIDTH(DEG_W), .DEPTH(MAX_PAGES)) u_deg (.clock, .wr_en(dg_we),
      .wr_addr(dg_wa), .wr_data(dg_wd), .rd_addr(dg_ra), .rd_data(dg_rd));
   prk_ram #(.WIDTH(32), .DEPTH(MAX_PAGES)) u_rank (.clock, .wr_en(rk_we),
      .wr_addr(rk_wa), .wr_data(rk_wd), .rd_addr(rk_ra), .rd_data(rk_rd));
   prk_ram #(.WIDTH(32), .DEPTH(MAX_PAGES)) u_next (.clock, .wr_en(nx_we),
      .wr_addr(nx_wa), .wr_data(nx_wd), .rd_addr(nx_ra), .rd_data(nx_rd));

   // shared divider: start rank, base share and every link share
   logic        dv_start, dv_done;
   logic [32:0] dv_num, dv_quo;
   logic [DEG_W+3:0] dv_den;
   prk_div #(.NUM_W(33), .DEN_W(DEG_W+4)) u_div (.clock, .reset,
      .start(dv_start), .num(dv_num), .den(dv_den), .done(dv_done),
      .quo(dv_quo));

   logic [32:0]       acc_sum;
   logic [NW+PA_W+7:0] n100;
   logic [71:0]       score_full;
   logic [PA_W-1:0]   pi;

   assign pi = pidx_ff[PA_W-1:0];
   assign req.ready = (state_ff == S_LOAD);
   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; eidx_in = eidx_ff;
      pidx_in = pidx_ff; round_in = round_ff; base_in = base_ff;
      start_in = start_ff; dsel_in = dsel_ff; es_in = es_ff; ed_in = ed_ff;
      prod_in = prod_ff; share_in = share_ff; rsp_in = rsp_ff;
      rsp_v_in = rsp_v_ff && !rsp.ready;
      e_we = 1'b0; e_wa = fill_ff[EA_W-1:0];
      e_wd = {req.data.src_page[PA_W-1:0], req.data.dst_page[PA_W-1:0]};
      e_ra = eidx_ff[EA_W-1:0];
      dg_we = 1'b0; dg_wa = es_ff; dg_wd = dg_rd + 1'b1; dg_ra = es_ff;
      rk_we = 1'b0; rk_wa = pi; rk_wd = start_ff; rk_ra = es_ff;
      nx_we = 1'b0; nx_wa = ed_ff; nx_wd = base_ff; nx_ra = ed_ff;
      dv_start = 1'b0; dv_num = 33'h1_0000_0000; dv_den = (DEG_W+4)'(n_used);
      acc_sum = {1'b0, nx_rd} + {1'b0, share_ff};
      n100 = (NW+PA_W+8)'(n_used) * (NW+PA_W+8)'(100);
      score_full = 72'(n100) * 72'(rk_rd);
      case (state_ff)
         S_LOAD: begin
            if (req.valid && req.ready) begin
               if (req.data.has_edge
                   && (NW+PA_W+1)'(req.data.src_page) < n_used
                   && (NW+PA_W+1)'(req.data.dst_page) < n_used
                   && fill_ff < EF_W'(MAX_EDGES)) begin
                  e_we = 1'b1; fill_in = fill_ff + 1'b1;
               end
               if (req.data.last_edge) begin
                  state_in = S_INIT; pidx_in = '0;
               end
            end
         end
         S_INIT: begin
            // clear out-degrees
            dg_we = 1'b1; dg_wa = pi; dg_wd = '0;
            pidx_in = pidx_ff + 1'b1;
            if (pidx_ff == (PA_W+1)'(MAX_PAGES - 1)) begin
               state_in = S_DIVS; dsel_in = 2'd0; dv_start = 1'b1;
            end
         end
         S_DIVS: begin
            if (dv_done) begin
               if (dsel_ff == 2'd0) begin
                  start_in = (dv_quo[32]) ? RANK_MAX : dv_quo[31:0];
                  dsel_in = 2'd1; dv_start = 1'b1;
                  dv_den = (DEG_W+4)'(n_used * 10);
               end else begin
                  base_in = dv_quo[31:0];
                  state_in = S_DEG_RD; eidx_in = '0;
               end
            end
         end
         S_DEG_RD: begin
            if (eidx_ff == fill_ff) begin
               state_in = S_COPY; pidx_in = '0; // rank init pass
               round_in = '0; dsel_in = 2'd2;
            end else state_in = S_DEG_WAIT;
         end
         S_DEG_WAIT: begin
            es_in = e_rd[2*PA_W-1:PA_W]; dg_ra = e_rd[2*PA_W-1:PA_W];
            state_in = S_DEG_UPD;
            // only links valid for the current page count are counted
            if ((NW+PA_W+1)'(e_rd[2*PA_W-1:PA_W]) >= n_used
                || (NW+PA_W+1)'(e_rd[PA_W-1:0]) >= n_used) begin
               eidx_in = eidx_ff + 1'b1; state_in = S_DEG_RD;
            end
         end
         S_DEG_UPD: begin
            dg_we = 1'b1; eidx_in = eidx_ff + 1'b1; state_in = S_DEG_RD;
         end
         S_COPY: begin
            // dsel 2: rank <= start; 3: rank <= next (read one ahead)
            nx_ra = pi;
            if (dsel_ff == 2'd2) begin
               rk_we = 1'b1; rk_wd = start_ff;
               pidx_in = pidx_ff + 1'b1;
               if (pidx_ff == n_used[PA_W:0] - 1'b1) begin
                  state_in = S_ACC_CLR; pidx_in = '0;
               end
            end else begin
               state_in = S_E_MUL; es_in = pi; // reuse: S_E_MUL waits for the read
            end
         end
         S_ACC_CLR: begin
            if (round_ff == round_count_ff) begin
               state_in = S_REP; pidx_in = '0;
            end else begin
               nx_we = 1'b1; nx_wa = pi; nx_wd = base_ff;
               pidx_in = pidx_ff + 1'b1;
               if (pidx_ff == n_used[PA_W:0] - 1'b1) begin
                  state_in = S_E_RD; eidx_in = '0;
               end
            end
         end
         S_E_RD: begin
            if (eidx_ff == fill_ff) begin
               state_in = S_COPY; dsel_in = 2'd3; pidx_in = '0;
            end else state_in = S_E_WAIT;
         end
         S_E_WAIT: begin
            es_in = e_rd[2*PA_W-1:PA_W]; ed_in = e_rd[PA_W-1:0];
            rk_ra = e_rd[2*PA_W-1:PA_W]; dg_ra = e_rd[2*PA_W-1:PA_W];
            eidx_in = eidx_ff + 1'b1;
            state_in = S_E_MUL; dsel_in = 2'd0;
            // links that became out of range after loading are skipped
            if ((NW+PA_W+1)'(e_rd[2*PA_W-1:PA_W]) >= n_used
                || (NW+PA_W+1)'(e_rd[PA_W-1:0]) >= n_used) state_in = S_E_RD;
         end
         S_E_MUL: begin
            if (dsel_ff == 2'd3) begin
               // copy step: next read at pi arrives now
               rk_we = 1'b1; rk_wa = pi; rk_wd = nx_rd;
               pidx_in = pidx_ff + 1'b1;
               if (pidx_ff == n_used[PA_W:0] - 1'b1) begin
                  state_in = S_ACC_CLR; pidx_in = '0;
                  round_in = round_ff + 1'b1;
               end else state_in = S_COPY;
            end else begin
               prod_in = 64'(rk_rd) * 64'(NINE_TENTHS_Q32);
               state_in = S_E_DIV;
               if (dg_rd == '0) state_in = S_E_RD;
               else dv_start = 1'b0;
            end
         end
         S_E_DIV: begin
            if (dsel_ff == 2'd0) begin
               dv_start = 1'b1; dv_num = {1'b0, prod_ff[63:32]};
               dv_den = (DEG_W+4)'(dg_rd); dsel_in = 2'd1;
            end else if (dv_done) begin
               share_in = dv_quo[31:0]; state_in = S_E_ACC;
            end
         end
         S_E_ACC: begin
            nx_we = 1'b1;
            nx_wd = acc_sum[32] ? RANK_MAX : acc_sum[31:0];
            state_in = S_E_RD;
         end
         S_REP: begin
            rk_ra = pi; state_in = S_REP_WAIT;
         end
         S_REP_WAIT: begin
            rk_ra = pi; state_in = S_REP_OUT;
         end
         S_REP_OUT: begin
            rk_ra = pi;
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1;
               rsp_in.page_index = PAGE_W'(pi);
               rsp_in.rank = rk_rd;
               rsp_in.score = (score_full[71:32] > 40'(SCORE_MAX)) ? SCORE_MAX
                              : score_full[44:32];
               rsp_in.last_page = (pidx_ff == n_used[PA_W:0] - 1'b1);
               pidx_in = pidx_ff + 1'b1;
               state_in = S_REP;
               if (pidx_ff == n_used[PA_W:0] - 1'b1) begin
                  state_in = S_LOAD; fill_in = '0;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      eidx_ff <= eidx_in; pidx_ff <= pidx_in; round_ff <= round_in;
      base_ff <= base_in; start_ff <= start_in; dsel_ff <= dsel_in;
      es_ff <= es_in; ed_ff <= ed_in; prod_ff <= prod_in;
      share_ff <= share_in; rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= S_LOAD; fill_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; rsp_v_ff <= rsp_v_in;
      end
   end
endmodule
